// ----- rtl/core/moving_average_threshold_unit_assert.svh -----
// assertion macros shared by the moving average threshold unit
`ifndef MOVING_AVERAGE_THRESHOLD_UNIT_ASSERT_SVH
`define MOVING_AVERAGE_THRESHOLD_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MATU_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define MATU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/matu_pkg.sv -----
// shared constants and types of the moving average threshold unit
package matu_pkg;

    // field widths
    localparam int SAMPLE_W = 12;
    localparam int THRESH_W = 12;
    localparam int MEAN_W   = 16;
    localparam int HC_W     = 5;
    localparam int FRAC_W   = 4;

    // defaults
    localparam int                  WINDOW_LEN_DEF = 16;
    localparam logic [THRESH_W-1:0] THRESH_RESET   = 12'd2000;
    localparam logic [MEAN_W-1:0]   MEAN_MAX       = 16'd65520;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // front status toward the top level
    typedef struct packed {
        logic pend;
        logic accept;
    } t_front_status;

    // queue status
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// ----- rtl/core/matu_front.sv -----
// front end: accepts samples, keeps the ring, fill count and running sum
module matu_front #(
    parameter int WINDOW_LEN = matu_pkg::WINDOW_LEN_DEF,
    parameter int SUM_W      = matu_pkg::SAMPLE_W + $clog2(WINDOW_LEN),
    parameter int CNT_W      = $clog2(WINDOW_LEN + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [matu_pkg::SAMPLE_W-1:0] i_sample_value,
    input  matu_pkg::t_queue_status       i_q_status,
    output logic                          o_push,
    output logic [SUM_W-1:0]              o_push_sum,
    output logic [CNT_W-1:0]              o_push_fill,
    output matu_pkg::t_front_status       o_status
);

    localparam int PTR_W = $clog2(WINDOW_LEN);

    logic [matu_pkg::SAMPLE_W-1:0] r_ring [WINDOW_LEN];
    logic [PTR_W-1:0]              r_wp;
    logic [CNT_W-1:0]              r_fill;
    logic [SUM_W-1:0]              r_sum;
    logic                          r_pend;
    logic [matu_pkg::SAMPLE_W-1:0] r_old;
    logic [matu_pkg::SAMPLE_W-1:0] r_sample;
    logic                          r_drop;
    logic                          accept;
    logic                          full;
    logic [SUM_W-1:0]              n_sum;

    // one sample in flight; the queue must have room for it
    assign o_stall = r_pend || i_q_status.full;
    assign accept  = i_valid && !o_stall;
    assign full    = (r_fill == CNT_W'(WINDOW_LEN));

    // ring write and read of the oldest word at the same address
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ring[r_wp] <= i_sample_value;
            r_old        <= r_ring[r_wp];
            r_sample     <= i_sample_value;
            r_drop       <= full;
        end
    end

    // running sum after the drop and the add
    assign n_sum = r_sum - (r_drop ? SUM_W'(r_old) : '0) + SUM_W'(r_sample);

    // pointer, fill count, sum and pending flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
            r_sum  <= '0;
            r_pend <= 1'b0;
        end else begin
            if (accept) begin
                r_wp   <= (r_wp == PTR_W'(WINDOW_LEN - 1)) ? '0 : r_wp + 1'b1;
                r_fill <= full ? r_fill : r_fill + 1'b1;
                r_pend <= 1'b1;
            end else if (r_pend) begin
                r_pend <= 1'b0;
            end
            if (r_pend) begin
                r_sum <= n_sum;
            end
        end
    end

    // hand the updated sum and count to the queue
    assign o_push      = r_pend;
    assign o_push_sum  = n_sum;
    assign o_push_fill = r_fill;

    assign o_status.pend   = r_pend;
    assign o_status.accept = accept;

endmodule

// ----- rtl/core/matu_queue.sv -----
// short queue between the front end and the divider back end
module matu_queue #(
    parameter int WIDTH = 21
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [WIDTH-1:0]        i_data,
    input  logic                    i_pop,
    output logic [WIDTH-1:0]        o_data,
    output matu_pkg::t_queue_status o_status
);

    localparam int PTR_W = $clog2(matu_pkg::QUEUE_DEPTH);
    localparam int QC_W  = $clog2(matu_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [matu_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [QC_W-1:0]  r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_cnt == QC_W'(matu_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_data         = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(matu_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(matu_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/core/matu_back.sv -----
// back end: serial mean divider, alarm compare and output register
module matu_back #(
    parameter int SUM_W = matu_pkg::SAMPLE_W + 4,
    parameter int CNT_W = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [SUM_W-1:0]              i_q_sum,
    input  logic [CNT_W-1:0]              i_q_fill,
    input  matu_pkg::t_queue_status       i_q_status,
    output logic                          o_pop,
    input  logic [matu_pkg::THRESH_W-1:0] i_thresh,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [matu_pkg::MEAN_W-1:0]   o_mean_q4,
    output logic [matu_pkg::HC_W-1:0]     o_held_count,
    output logic                          o_alarm
);

    localparam int DW    = SUM_W + matu_pkg::FRAC_W;
    localparam int DC_W  = $clog2(DW + 1);
    localparam int PR_W  = matu_pkg::THRESH_W + CNT_W;
    localparam int HX_W  = matu_pkg::HC_W + CNT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]       r_state;
    logic [DW-1:0]    r_quo;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_div;
    logic [DC_W-1:0]  r_cnt;
    logic             r_alarm;
    logic [HX_W-1:0]  r_hc;
    logic             r_out_valid;
    logic [matu_pkg::MEAN_W-1:0] r_out_mean;
    logic [matu_pkg::HC_W-1:0]   r_out_hc;
    logic                        r_out_alarm;

    logic [CNT_W:0]   shifted;
    logic             fits;
    logic [CNT_W:0]   diff;
    logic [PR_W-1:0]  product;
    logic             out_free;

    // one restoring divide step
    assign shifted = {r_rem, r_quo[DW-1]};
    assign fits    = (shifted >= {1'b0, r_div});
    assign diff    = shifted - {1'b0, r_div};

    // threshold times count for the alarm compare
    assign product  = PR_W'(i_thresh) * PR_W'(i_q_fill);
    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == ST_IDLE) && !i_q_status.empty;

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_cnt == DC_W'(1)) begin
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // divider registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_quo   <= {i_q_sum, matu_pkg::FRAC_W'(0)};
            r_rem   <= '0;
            r_div   <= i_q_fill;
            r_cnt   <= DC_W'(DW);
            r_alarm <= (PR_W'(i_q_sum) > product);
            r_hc    <= HX_W'(i_q_fill);
        end else if (r_state == ST_DIV) begin
            r_quo <= {r_quo[DW-2:0], fits};
            r_rem <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_WAIT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_WAIT) && out_free) begin
            r_out_mean  <= r_quo[matu_pkg::MEAN_W-1:0];
            r_out_hc    <= r_hc[matu_pkg::HC_W-1:0];
            r_out_alarm <= r_alarm;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_mean_q4    = r_out_mean;
    assign o_held_count = r_out_hc;
    assign o_alarm      = r_out_alarm;

endmodule

// ----- rtl/core/moving_average_threshold_unit.sv -----
// top level of the moving average threshold unit
// Usage:
// - input channel: i_valid / o_stall with i_sample_value; a word is taken at a
//   clock edge with i_valid high and o_stall low
// - output channel: o_valid / i_stall with o_mean_q4, o_held_count, o_alarm;
//   one result word per input word, in order
// - i_cfg_we / i_cfg_data write the alarm threshold; write only while idle
// - the front end updates the ring and running sum and queues the sum; the
//   back end runs a restoring divider, one quotient bit per cycle
// - a word passes from the accepting edge through the ring update, the queue,
//   the divider and the output register to o_valid; the serial divider sets
//   the throughput
// - the front end keeps accepting while a result waits in the output
//   register, until the two-entry queue fills
// - synchronous active-low reset empties the window, clears the sum and
//   restores the threshold to 2000; the ring needs no clearing pass
// - while i_stall is high the output word is held unchanged
module moving_average_threshold_unit #(
    parameter int WINDOW_LEN = matu_pkg::WINDOW_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [matu_pkg::SAMPLE_W-1:0] i_sample_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [matu_pkg::MEAN_W-1:0]   o_mean_q4,
    output logic [matu_pkg::HC_W-1:0]     o_held_count,
    output logic                          o_alarm,
    input  logic                          i_cfg_we,
    input  logic [matu_pkg::THRESH_W-1:0] i_cfg_data
);

    `include "moving_average_threshold_unit_assert.svh"

    localparam int SUM_W = matu_pkg::SAMPLE_W + $clog2(WINDOW_LEN);
    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam int Q_W   = SUM_W + CNT_W;

    logic [matu_pkg::THRESH_W-1:0] r_thresh;
    logic                          push;
    logic [SUM_W-1:0]              push_sum;
    logic [CNT_W-1:0]              push_fill;
    logic                          pop;
    logic [Q_W-1:0]                q_data;
    matu_pkg::t_front_status       front_status;
    matu_pkg::t_queue_status       q_status;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= matu_pkg::THRESH_RESET;
        end else if (i_cfg_we) begin
            r_thresh <= i_cfg_data;
        end
    end

    // front end
    matu_front #(
        .WINDOW_LEN (WINDOW_LEN),
        .SUM_W      (SUM_W),
        .CNT_W      (CNT_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample_value (i_sample_value),
        .i_q_status     (q_status),
        .o_push         (push),
        .o_push_sum     (push_sum),
        .o_push_fill    (push_fill),
        .o_status       (front_status)
    );

    // queue
    matu_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   ({push_sum, push_fill}),
        .i_pop    (pop),
        .o_data   (q_data),
        .o_status (q_status)
    );

    // back end
    matu_back #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_sum      (q_data[Q_W-1:CNT_W]),
        .i_q_fill     (q_data[CNT_W-1:0]),
        .i_q_status   (q_status),
        .o_pop        (pop),
        .i_thresh     (r_thresh),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_mean_q4    (o_mean_q4),
        .o_held_count (o_held_count),
        .o_alarm      (o_alarm)
    );

    // a pending sum always finds room in the queue
    `MATU_ASSERT_IMPL(a_push_room, front_status.pend, !q_status.full)
    // an accepted word is pushed in the following cycle
    `MATU_ASSERT_NEXT(a_accept_push, front_status.accept, push)
    // the mean never exceeds the largest sample in q4 form
    `MATU_ASSERT_IMPL(a_mean_range, o_valid, o_mean_q4 <= matu_pkg::MEAN_MAX)

endmodule
